// ===== sv/sct_pkg.sv =====
// Shared types, token kinds and keyword tables for the script character tokenizer.
`default_nettype none

package sct_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned NUM_KW        = 6;
  localparam int unsigned KW_MAXLEN     = 9;
  localparam int unsigned KW_IDX_W      = $clog2(KW_MAXLEN);
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_IDX_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [3:0] KIND_EQUAL    = 4'd0;
  localparam logic [3:0] KIND_LPAREN   = 4'd1;
  localparam logic [3:0] KIND_RPAREN   = 4'd2;
  localparam logic [3:0] KIND_COMMA    = 4'd3;
  localparam logic [3:0] KIND_NUMBER   = 4'd4;
  localparam logic [3:0] KIND_IDENT    = 4'd5;
  localparam logic [3:0] KIND_KEYWORD0 = 4'd6;
  localparam logic [3:0] KIND_BAD      = 4'd12;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
    '{"c", "o", "n", "n", "e", "c", "t", 8'h00, 8'h00},
    '{"p", "o", "w", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "s", "i", "s", "t", "o", "r", 8'h00},
    '{"c", "a", "p", "a", "c", "i", "t", "o", "r"},
    '{"g", "r", "o", "u", "n", "d", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "d", "u", "c", "t", "o", "r", 8'h00}
  };

  localparam logic [15:0] KW_LEN [NUM_KW] = '{
    16'd7, 16'd5, 16'd8, 16'd9, 16'd6, 16'd8
  };

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_INT   = 4'b0010,
    MODE_FRAC  = 4'b0100,
    MODE_IDENT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  // Keeps the keywords that still match after character c at offset at.
  function automatic logic [NUM_KW-1:0] kw_narrow(input logic [NUM_KW-1:0] mask,
                                                  input logic [15:0] at,
                                                  input logic [7:0] c);
    logic [NUM_KW-1:0] res;
    res = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (mask[k] && (at < KW_LEN[k]) && (KW_TEXT[k][at[KW_IDX_W-1:0]] == c)) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/script_char_tokenizer.sv =====
// Top level of the script character tokenizer: scanner state and result queue.
// A token is written into the result queue when the character that ends it is accepted.
// Throughput: one character per cycle while in_stall is low; a character that ends a token
// and is itself a token gives two results, drained one per cycle from a four-entry
// result queue while out_stall is low. Input stalls while fewer than two queue entries are free.
// Reset (synchronous) empties the queue, sets the scanner idle and position to zero.
`default_nettype none

module script_char_tokenizer #(
  parameter int unsigned POS_WIDTH = sct_pkg::POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        is_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       kind,
  output logic [15:0]      start_pos,
  output logic [15:0]      token_len,
  output logic             last
);

  localparam logic [sct_pkg::NUM_KW-1:0] KW_ALL = '1;

  sct_pkg::mode_t            mode, mode_next;
  logic [POS_WIDTH-1:0]      pos, pos_next;
  logic [POS_WIDTH-1:0]      pstart, pstart_next;
  logic [15:0]               plen, plen_next;
  logic [sct_pkg::NUM_KW-1:0] cand, cand_next;

  sct_pkg::tok_t             fifo [sct_pkg::FIFO_DEPTH];
  logic [sct_pkg::FIFO_IDX_W-1:0] wr_ptr, rd_ptr;
  logic [sct_pkg::FIFO_CNT_W-1:0] count;

  logic                      in_acc, out_acc;
  logic                      v0, v1;
  sct_pkg::tok_t             r0, r1, push_a;
  logic [1:0]                push_n;
  logic [3:0]                fkind, pkind;
  logic [15:0]               plen_inc;
  logic                      is_digit, is_letter, is_blank, is_punct;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (count > sct_pkg::FIFO_CNT_W'(sct_pkg::FIFO_DEPTH - 2));
  assign out_valid = (count != '0);

  assign kind      = fifo[rd_ptr].kind;
  assign start_pos = fifo[rd_ptr].start;
  assign token_len = fifo[rd_ptr].len;
  assign last      = fifo[rd_ptr].last;

  assign is_digit  = (ch >= "0") && (ch <= "9");
  assign is_letter = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  assign is_blank  = (ch == " ") || (ch == 8'h09) || (ch == 8'h0D) || (ch == 8'h0A);
  assign is_punct  = (ch == "=") || (ch == "(") || (ch == ")") || (ch == ",");
  assign plen_inc  = (plen == sct_pkg::LEN_MAX) ? plen : plen + 16'd1;

  always_comb begin
    unique case (ch)
      "=":     pkind = sct_pkg::KIND_EQUAL;
      "(":     pkind = sct_pkg::KIND_LPAREN;
      ")":     pkind = sct_pkg::KIND_RPAREN;
      default: pkind = sct_pkg::KIND_COMMA;
    endcase
  end

  // Kind of the pending token if it were emitted now; the lowest matching keyword wins.
  always_comb begin
    fkind = sct_pkg::KIND_NUMBER;
    if (mode == sct_pkg::MODE_IDENT) begin
      fkind = sct_pkg::KIND_IDENT;
      for (int k = sct_pkg::NUM_KW - 1; k >= 0; k--) begin
        if (cand[k] && (plen == sct_pkg::KW_LEN[k])) begin
          fkind = 4'(sct_pkg::KIND_KEYWORD0 + 4'(k));
        end
      end
    end
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    pstart_next = pstart;
    plen_next   = plen;
    cand_next   = cand;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '{kind: fkind, start: 16'(pstart), len: plen, last: 1'b1};
    r1 = '{kind: sct_pkg::KIND_BAD, start: 16'(pos), len: 16'd1, last: 1'b1};
    if (in_acc) begin
      if (is_end) begin
        v0        = (mode != sct_pkg::MODE_IDLE);
        mode_next = sct_pkg::MODE_IDLE;
        plen_next = '0;
        cand_next = KW_ALL;
        pos_next  = '0;
      end else begin
        pos_next = pos + POS_WIDTH'(1);
        priority if (mode == sct_pkg::MODE_INT && (is_digit || ch == ".")) begin
          plen_next = plen_inc;
          if (ch == ".") begin
            mode_next = sct_pkg::MODE_FRAC;
          end
        end else if (mode == sct_pkg::MODE_FRAC && is_digit) begin
          plen_next = plen_inc;
        end else if (mode == sct_pkg::MODE_IDENT && (is_letter || is_digit)) begin
          cand_next = sct_pkg::kw_narrow(cand, plen, ch);
          plen_next = plen_inc;
        end else begin
          v0        = (mode != sct_pkg::MODE_IDLE);
          mode_next = sct_pkg::MODE_IDLE;
          plen_next = '0;
          cand_next = KW_ALL;
          priority if (is_blank) begin
            v1 = 1'b0;
          end else if (is_punct) begin
            v1      = 1'b1;
            r1.kind = pkind;
          end else if (is_digit) begin
            mode_next   = sct_pkg::MODE_INT;
            pstart_next = pos;
            plen_next   = 16'd1;
          end else if (is_letter) begin
            mode_next   = sct_pkg::MODE_IDENT;
            pstart_next = pos;
            plen_next   = 16'd1;
            cand_next   = sct_pkg::kw_narrow(KW_ALL, 16'd0, ch);
          end else begin
            v1 = 1'b1;
          end
        end
      end
    end
    r0.last = !v1;
    push_a  = v0 ? r0 : r1;
    push_n  = {1'b0, v0} + {1'b0, v1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sct_pkg::MODE_IDLE;
      pos    <= '0;
      pstart <= '0;
      plen   <= '0;
      cand   <= KW_ALL;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      cand   <= cand_next;
      wr_ptr <= wr_ptr + sct_pkg::FIFO_IDX_W'(push_n);
      rd_ptr <= rd_ptr + sct_pkg::FIFO_IDX_W'(out_acc);
      count  <= count + sct_pkg::FIFO_CNT_W'(push_n) - sct_pkg::FIFO_CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + sct_pkg::FIFO_IDX_W'(1)] <= r1;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sct_pkg::FIFO_CNT_W'(sct_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    (mode == sct_pkg::MODE_IDLE) |-> (plen == 16'd0))
    else $error("idle scanner holds a pending length");

  a_end_rewind: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_end) |=> (pos == '0) && (mode == sct_pkg::MODE_IDLE))
    else $error("end marker did not rewind the scanner");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_len != 16'd0))
    else $error("empty token emitted");
`endif

endmodule

`default_nettype wire
